/* rtl/core/onewire_thermometer_command_layer_macros.svh */
// Assertion macros shared by the command layer RTL.
// The clock is named clock and the synchronous reset is named reset.
`ifndef ONEWIRE_THERMOMETER_COMMAND_LAYER_MACROS_SVH
`define ONEWIRE_THERMOMETER_COMMAND_LAYER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication.
`define OTCL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define OTCL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define OTCL_ASSERT_NOW(label, ante, cons, msg)
`define OTCL_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* rtl/core/otcl_pkg.sv */
package otcl_pkg;

   // Command bytes.
   localparam logic [7:0] CMD_ROM_READ = 8'h33;
   localparam logic [7:0] CMD_ROM_SKIP = 8'hCC;
   localparam logic [7:0] CMD_CONVERT  = 8'h44;
   localparam logic [7:0] CMD_READ_PAD = 8'hBE;

   // Request kinds carried on tuser.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   localparam logic [7:0] IDLE_BYTE = 8'hFF;
   localparam logic [7:0] CRC_POLY  = 8'h8C;

   localparam int TEMP_W = 12;
   localparam int POS_W  = 4;

   localparam logic [POS_W-1:0] PAD_LEN = 4'd9;
   localparam logic [POS_W-1:0] ROM_LEN = 4'd8;

   localparam logic [TEMP_W-1:0] TEMP_RESET   = 12'd400;
   localparam logic [63:0]       ROM_ID_RESET = 64'h2800_0000_0000_0100;

   // Configuration port.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_SEL_BIT = 3;
   localparam logic REG_ROM_ID      = 1'b0;
   localparam logic REG_TEMPERATURE = 1'b1;

   // Scratchpad bytes two through seven.
   localparam logic [7:0] PAD_FIXED [6] = '{8'h4B, 8'h46, 8'h7F, 8'hFF, 8'h0C, 8'h10};

   typedef enum logic [1:0] {
      SRC_NONE = 2'd0,
      SRC_PAD  = 2'd1,
      SRC_ROM  = 2'd2
   } src_type;

   typedef logic [7:0] crc_cols_type [16];

   // One byte through the reflected CRC-8, a bit at a time.
   function automatic logic [7:0] crc_byte(input logic [7:0] crc_i, input logic [7:0] data_i);
      logic [7:0] crc;
      logic [7:0] data;
      crc  = crc_i;
      data = data_i;
      for (int i = 0; i < 8; i++) begin
         if ((crc[0] ^ data[0]) == 1'b1) begin
            crc = (crc >> 1) ^ CRC_POLY;
         end else begin
            crc = crc >> 1;
         end
         data = data >> 1;
      end
      return crc;
   endfunction

   // Check byte of the first eight scratchpad bytes for a given 16-bit temperature.
   // Only evaluated at elaboration.
   function automatic logic [7:0] pad_crc(input logic [15:0] temp16);
      logic [7:0] crc;
      crc = crc_byte(8'h00, temp16[7:0]);
      crc = crc_byte(crc, temp16[15:8]);
      for (int i = 0; i < 6; i++) begin
         crc = crc_byte(crc, PAD_FIXED[i]);
      end
      return crc;
   endfunction

   // The CRC is linear in the temperature bits: each bit contributes a fixed column.
   function automatic crc_cols_type crc_columns();
      crc_cols_type cols;
      for (int i = 0; i < 16; i++) begin
         cols[i] = pad_crc(16'(1) << i) ^ pad_crc(16'h0000);
      end
      return cols;
   endfunction

   localparam logic [7:0]   CRC_BASE = pad_crc(16'h0000);
   localparam crc_cols_type CRC_COLS = crc_columns();
   localparam logic [7:0]   CRC_RESET = pad_crc({{(16-TEMP_W){TEMP_RESET[TEMP_W-1]}}, TEMP_RESET});

   // Runtime check byte: an XOR tree over the sign-extended temperature.
   function automatic logic [7:0] temp_crc(input logic [TEMP_W-1:0] temp);
      logic [15:0] temp16;
      logic [7:0]  crc;
      temp16 = {{(16-TEMP_W){temp[TEMP_W-1]}}, temp};
      crc = CRC_BASE;
      for (int i = 0; i < 16; i++) begin
         if (temp16[i]) begin
            crc = crc ^ CRC_COLS[i];
         end
      end
      return crc;
   endfunction

endpackage

/* rtl/core/otcl_pad.sv */
module otcl_pad (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          latch,
   input  logic [otcl_pkg::TEMP_W-1:0]   temperature,
   input  logic [otcl_pkg::POS_W-1:0]    index,
   output logic [7:0]                    pad_byte
);

   logic [otcl_pkg::TEMP_W-1:0] held_temp_ff;
   logic [otcl_pkg::TEMP_W-1:0] held_temp_in;
   logic [7:0]                  check_ff;
   logic [7:0]                  check_in;

   always_comb begin
      held_temp_in = held_temp_ff;
      check_in     = check_ff;
      if (latch) begin
         held_temp_in = temperature;
         check_in     = otcl_pkg::temp_crc(temperature);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_temp_ff <= otcl_pkg::TEMP_RESET;
         check_ff     <= otcl_pkg::CRC_RESET;
      end else begin
         held_temp_ff <= held_temp_in;
         check_ff     <= check_in;
      end
   end

   always_comb begin
      case (index)
         4'd0: pad_byte = held_temp_ff[7:0];
         4'd1: pad_byte = {{(16-otcl_pkg::TEMP_W){held_temp_ff[otcl_pkg::TEMP_W-1]}},
                           held_temp_ff[otcl_pkg::TEMP_W-1:8]};
         4'd2: pad_byte = otcl_pkg::PAD_FIXED[0];
         4'd3: pad_byte = otcl_pkg::PAD_FIXED[1];
         4'd4: pad_byte = otcl_pkg::PAD_FIXED[2];
         4'd5: pad_byte = otcl_pkg::PAD_FIXED[3];
         4'd6: pad_byte = otcl_pkg::PAD_FIXED[4];
         4'd7: pad_byte = otcl_pkg::PAD_FIXED[5];
         4'd8: pad_byte = check_ff;
         default: pad_byte = otcl_pkg::IDLE_BYTE;
      endcase
   end

endmodule

/* rtl/core/onewire_thermometer_command_layer.sv */
// Byte-level command layer of a one-wire digital thermometer.
// The req channel carries one request per transfer: tuser says whether the
// master writes a command byte (0) or reads a byte (1); tdata holds the
// command byte. Every request yields exactly one rsp transfer holding the
// byte read (0 for writes, FF once the queue is empty) and the count of
// response bytes still queued.
// The response is registered at the edge that takes the request. Throughput
// is one request per cycle while responses are taken; all work for a
// request is a single pass of shallow logic, the widest part being the
// check byte XOR tree that a convert command loads into the scratchpad.
// If the receiver stalls, the response register holds its contents and
// req_tready drops until the response is taken.
// The APB port holds the identity code (offset 0x0) and the temperature
// (offset 0x8); write them only while no request is in flight.
// Reset restores the default identity code and a temperature of 25 C,
// latches it into the scratchpad and empties the response queue.
`include "onewire_thermometer_command_layer_macros.svh"

module onewire_thermometer_command_layer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] data_byte
   input  logic [0:0]                        req_tuser,   // [0] op
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [15:0]                       rsp_tdata,   // [7:0] read_data, [11:8] bytes_left
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [otcl_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [otcl_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [otcl_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   logic [63:0]                   rom_id_ff;
   logic [otcl_pkg::TEMP_W-1:0]   temperature_ff;
   otcl_pkg::src_type             src_ff;
   otcl_pkg::src_type             src_in;
   logic [otcl_pkg::POS_W-1:0]    pos_ff;
   logic [otcl_pkg::POS_W-1:0]    pos_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [7:0]                    rsp_data_ff;
   logic [7:0]                    rsp_data_in;
   logic [otcl_pkg::POS_W-1:0]    rsp_left_ff;
   logic [otcl_pkg::POS_W-1:0]    rsp_left_in;

   logic                          req_accept;
   logic                          csr_write;
   logic                          latch;
   logic [otcl_pkg::POS_W-1:0]    cur_len;
   logic [otcl_pkg::POS_W-1:0]    new_len;
   logic [7:0]                    pad_byte;
   logic [7:0]                    rom_byte;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      case (csr_paddr[otcl_pkg::CSR_SEL_BIT])
         otcl_pkg::REG_ROM_ID:      csr_prdata = rom_id_ff;
         otcl_pkg::REG_TEMPERATURE: csr_prdata = {{(otcl_pkg::CSR_DATA_W-otcl_pkg::TEMP_W){1'b0}},
                                                   temperature_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_id_ff      <= otcl_pkg::ROM_ID_RESET;
         temperature_ff <= otcl_pkg::TEMP_RESET;
      end else if (csr_write) begin
         if (csr_paddr[otcl_pkg::CSR_SEL_BIT] == otcl_pkg::REG_TEMPERATURE) begin
            temperature_ff <= csr_pwdata[otcl_pkg::TEMP_W-1:0];
         end else begin
            rom_id_ff <= csr_pwdata;
         end
      end
   end

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_accept = req_tvalid & req_tready;
   assign latch      = req_accept & (req_tuser[0] == otcl_pkg::OP_WRITE) &
                       (req_tdata == otcl_pkg::CMD_CONVERT);

   otcl_pad u_pad (
      .clock       (clock),
      .reset       (reset),
      .latch       (latch),
      .temperature (temperature_ff),
      .index       (pos_ff),
      .pad_byte    (pad_byte)
   );

   // ROM bytes come from the live register, least significant byte first.
   assign rom_byte = 8'(rom_id_ff >> {pos_ff[2:0], 3'b000});

   always_comb begin
      case (src_ff)
         otcl_pkg::SRC_PAD: cur_len = otcl_pkg::PAD_LEN;
         otcl_pkg::SRC_ROM: cur_len = otcl_pkg::ROM_LEN;
         default:           cur_len = '0;
      endcase
   end

   always_comb begin
      case (src_in)
         otcl_pkg::SRC_PAD: new_len = otcl_pkg::PAD_LEN;
         otcl_pkg::SRC_ROM: new_len = otcl_pkg::ROM_LEN;
         default:           new_len = '0;
      endcase
   end

   always_comb begin
      src_in      = src_ff;
      pos_in      = pos_ff;
      rsp_data_in = rsp_data_ff;
      if (req_accept) begin
         if (req_tuser[0] == otcl_pkg::OP_WRITE) begin
            case (req_tdata)
               otcl_pkg::CMD_READ_PAD: src_in = otcl_pkg::SRC_PAD;
               otcl_pkg::CMD_ROM_READ: src_in = otcl_pkg::SRC_ROM;
               default:                src_in = otcl_pkg::SRC_NONE;
            endcase
            pos_in      = '0;
            rsp_data_in = 8'h00;
         end else if (pos_ff < cur_len) begin
            rsp_data_in = (src_ff == otcl_pkg::SRC_PAD) ? pad_byte : rom_byte;
            pos_in      = pos_ff + 4'd1;
         end else begin
            rsp_data_in = otcl_pkg::IDLE_BYTE;
         end
      end
   end

   always_comb begin
      rsp_left_in = rsp_left_ff;
      if (req_accept) begin
         rsp_left_in = (pos_in < new_len) ? new_len - pos_in : '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff       <= otcl_pkg::SRC_NONE;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         src_ff       <= src_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_left_ff <= rsp_left_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'h0, rsp_left_ff, rsp_data_ff};

   `OTCL_ASSERT_NEXT(a_write_returns_zero,
      req_accept && req_tuser[0] == otcl_pkg::OP_WRITE,
      rsp_tdata[7:0] == 8'h00 && pos_ff == '0,
      "write request must return zero and rewind the queue")
   `OTCL_ASSERT_NEXT(a_exhausted_read,
      req_accept && req_tuser[0] == otcl_pkg::OP_READ && pos_ff >= cur_len,
      rsp_tdata[7:0] == otcl_pkg::IDLE_BYTE && pos_ff == $past(pos_ff) &&
         rsp_tdata[11:8] == 4'd0,
      "read past the queue must return FF and hold position")
   `OTCL_ASSERT_NOW(a_pos_in_range,
      rsp_valid_ff,
      pos_ff <= cur_len || src_ff == otcl_pkg::SRC_NONE,
      "read position beyond queue length")
   `OTCL_ASSERT_NOW(a_stall_only_when_full,
      !req_tready,
      rsp_valid_ff && !rsp_tready,
      "request stalled while the response register can take it")

endmodule

/* dv/onewire_thermometer_command_layer_tb.sv */
`timescale 1ns / 1ps

module onewire_thermometer_command_layer_tb;

   localparam int REQUESTS_TOTAL = 1850;

   typedef struct packed {
      logic [7:0] read_data;
      logic [3:0] bytes_left;
   } reply_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [7:0]                      req_tdata = 8'h00;   // [7:0] data_byte
   logic [0:0]                      req_tuser = 1'b0;    // [0] op
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [15:0]                     rsp_tdata;           // [7:0] read_data, [11:8] bytes_left
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [otcl_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [otcl_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [otcl_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   // Shadow of the sensor: registers and the state behind the response queue.
   logic [63:0]       shadow_rom_id;
   logic [11:0]       shadow_temp_reg;
   logic [15:0]       latched_temp;
   logic [7:0]        latched_check;
   otcl_pkg::src_type queue_source;
   logic [3:0]        queue_pos;

   reply_type replies_due[$];
   int        requests_sent = 0;
   int        mismatch_count = 0;
   int        req_gap_max = 7;
   int        rsp_gap_max = 7;
   int        rsp_hold = 0;

   onewire_thermometer_command_layer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Reflected CRC-8 over the first eight scratchpad bytes, one bit at a time
   // starting from the least significant bit of the temperature low byte.
   function automatic logic [7:0] scratchpad_check(input logic [15:0] temp16);
      logic [63:0] pad_bits;
      logic [7:0]  crc;
      pad_bits = {48'h100C_FF7F_464B, temp16};
      crc = 8'h00;
      for (int i = 0; i < 64; i++) begin
         if (crc[0] ^ pad_bits[i]) begin
            crc = (crc >> 1) ^ otcl_pkg::CRC_POLY;
         end else begin
            crc = crc >> 1;
         end
      end
      return crc;
   endfunction

   function automatic void latch_conversion();
      latched_temp  = {{4{shadow_temp_reg[11]}}, shadow_temp_reg};
      latched_check = scratchpad_check(latched_temp);
   endfunction

   function automatic logic [3:0] queued_length();
      case (queue_source)
         otcl_pkg::SRC_PAD: return otcl_pkg::PAD_LEN;
         otcl_pkg::SRC_ROM: return otcl_pkg::ROM_LEN;
         default: return 4'd0;
      endcase
   endfunction

   function automatic void sensor_reset();
      shadow_rom_id   = otcl_pkg::ROM_ID_RESET;
      shadow_temp_reg = otcl_pkg::TEMP_RESET;
      latch_conversion();
      queue_source = otcl_pkg::SRC_NONE;
      queue_pos    = 4'd0;
   endfunction

   // Advances the shadow state by one request and returns the reply it causes.
   function automatic reply_type sensor_reply(input logic op, input logic [7:0] data_byte);
      reply_type   r;
      logic [3:0]  len;
      logic [63:0] pad_low;
      r.read_data = 8'h00;
      if (op == otcl_pkg::OP_WRITE) begin
         if (data_byte == otcl_pkg::CMD_CONVERT) begin
            latch_conversion();
         end
         case (data_byte)
            otcl_pkg::CMD_READ_PAD: queue_source = otcl_pkg::SRC_PAD;
            otcl_pkg::CMD_ROM_READ: queue_source = otcl_pkg::SRC_ROM;
            default:                queue_source = otcl_pkg::SRC_NONE;
         endcase
         queue_pos = 4'd0;
      end else begin
         len = queued_length();
         if (queue_pos < len) begin
            pad_low = {48'h100C_FF7F_464B, latched_temp};
            if (queue_source == otcl_pkg::SRC_ROM) begin
               r.read_data = shadow_rom_id[8*queue_pos[2:0] +: 8];
            end else if (queue_pos == 4'd8) begin
               r.read_data = latched_check;
            end else begin
               r.read_data = pad_low[8*queue_pos[2:0] +: 8];
            end
            queue_pos = queue_pos + 4'd1;
         end else begin
            r.read_data = otcl_pkg::IDLE_BYTE;
         end
      end
      len = queued_length();
      r.bytes_left = (queue_pos < len) ? len - queue_pos : 4'd0;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // Every call starts and ends on a rising edge; the request valid stays high
   // when the next request follows without a gap.
   task automatic send_request(input logic op, input logic [7:0] data_byte);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data_byte;
      do @(posedge clock); while (!req_tready);
      replies_due.insert(replies_due.size(), sensor_reply(op, data_byte));
      requests_sent++;
   endtask

   task automatic read_bytes(input int count);
      repeat (count) send_request(otcl_pkg::OP_READ, 8'($urandom_range(0, 255)));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_write(input logic sel, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {{(otcl_pkg::CSR_ADDR_W-1){1'b0}}, sel} << otcl_pkg::CSR_SEL_BIT;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (sel == otcl_pkg::REG_ROM_ID) begin
         shadow_rom_id = value;
      end else begin
         shadow_temp_reg = value[11:0];
      end
   endtask

   task automatic write_temperature(input int temp);
      logic [11:0] t;
      t = 12'(temp);
      csr_write(otcl_pkg::REG_TEMPERATURE, {{52{t[11]}}, t});
   endtask

   task automatic check_reply(input logic [15:0] tdata);
      reply_type want;
      if (replies_due.size() == 0) begin
         report_mismatch($sformatf("response %h with no request outstanding", tdata));
      end else begin
         want = replies_due.pop_front();
         if (tdata[7:0] !== want.read_data) begin
            report_mismatch($sformatf("read_data %h, expected %h", tdata[7:0],
                                      want.read_data));
         end
         if (tdata[11:8] !== want.bytes_left) begin
            report_mismatch($sformatf("bytes_left %0d, expected %0d", tdata[11:8],
                                      want.bytes_left));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_reply(rsp_tdata);
            rsp_hold = $urandom_range(0, rsp_gap_max);
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_tready <= (rsp_hold == 0);
      end
   end

   // Out of reset: empty queue, scratchpad with the reset temperature and its
   // check byte, default identity, then commands that empty the queue.
   task automatic test_reset_contents();
      send_request(otcl_pkg::OP_READ, 8'h00);
      send_request(otcl_pkg::OP_WRITE, otcl_pkg::CMD_READ_PAD);
      read_bytes(10);
      send_request(otcl_pkg::OP_WRITE, otcl_pkg::CMD_ROM_READ);
      send_request(otcl_pkg::OP_READ, 8'hFF);
      read_bytes(8);
      send_request(otcl_pkg::OP_WRITE, otcl_pkg::CMD_ROM_SKIP);
      send_request(otcl_pkg::OP_READ, 8'h00);
      send_request(otcl_pkg::OP_WRITE, 8'hFF);
      send_request(otcl_pkg::OP_READ, 8'h00);
      drain();
   endtask

   // Range ends, zero, minus one and the 12-bit patterns beyond the range.
   task automatic test_temperature_extremes();
      int temps[7] = '{-880, 2000, 0, -1, -2048, 2047, 400};
      foreach (temps[i]) begin
         write_temperature(temps[i]);
         send_request(otcl_pkg::OP_WRITE, otcl_pkg::CMD_CONVERT);
         send_request(otcl_pkg::OP_WRITE, otcl_pkg::CMD_READ_PAD);
         read_bytes(9);
         drain();
      end
   endtask

   // The identity is read live, so a write in the middle of a ROM read shows
   // up in the bytes that follow it.
   task automatic test_identity_updates();
      logic [63:0] ids[4] = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_AAAA_3333_CCCC,
                              {$urandom, $urandom}};
      foreach (ids[i]) begin
         csr_write(otcl_pkg::REG_ROM_ID, ids[i]);
         send_request(otcl_pkg::OP_WRITE, otcl_pkg::CMD_ROM_READ);
         read_bytes(3);
         drain();
         csr_write(otcl_pkg::REG_ROM_ID, ~ids[i]);
         read_bytes(6);
         drain();
      end
      // A temperature write without a convert must leave the scratchpad alone.
      write_temperature(-1);
      send_request(otcl_pkg::OP_WRITE, otcl_pkg::CMD_READ_PAD);
      read_bytes(9);
      drain();
   endtask

   task automatic test_random_traffic();
      int          seq_count;
      int          reads;
      int          pick;
      logic [7:0]  command;
      seq_count = 0;
      while (requests_sent < REQUESTS_TOTAL) begin
         if (seq_count % 40 == 0) begin
            drain();
            case ($urandom_range(0, 4))
               0: begin req_gap_max = 0; rsp_gap_max = 0; end
               1: begin req_gap_max = 7; rsp_gap_max = 0; end
               2: begin req_gap_max = 0; rsp_gap_max = 7; end
               default: begin req_gap_max = 7; rsp_gap_max = 7; end
            endcase
            if ($urandom_range(0, 1)) begin
               csr_write(otcl_pkg::REG_ROM_ID, {$urandom, $urandom});
            end
            if ($urandom_range(0, 3) == 0) begin
               write_temperature($urandom_range(0, 4095));
            end else begin
               write_temperature(int'($urandom_range(0, 2880)) - 880);
            end
         end
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            command = otcl_pkg::CMD_READ_PAD;
         end else if (pick < 58) begin
            command = otcl_pkg::CMD_ROM_READ;
         end else if (pick < 75) begin
            command = otcl_pkg::CMD_CONVERT;
         end else if (pick < 80) begin
            command = otcl_pkg::CMD_ROM_SKIP;
         end else begin
            command = 8'($urandom_range(0, 255));
         end
         // Now and then a run of reads with no fresh command in front of it.
         if ($urandom_range(0, 9) != 0) begin
            send_request(otcl_pkg::OP_WRITE, command);
         end
         reads = $urandom_range(0, 11);
         read_bytes(reads);
         seq_count++;
      end
      drain();
   endtask

   initial begin
      sensor_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_contents();
      test_temperature_extremes();
      test_identity_updates();
      test_random_traffic();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && replies_due.size() == 0) begin
         $display("onewire_thermometer_command_layer regression: pass");
      end else begin
         $display("onewire_thermometer_command_layer regression: fail");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("onewire_thermometer_command_layer regression: fail");
      $finish;
   end

endmodule
